[src/ffb_pkg.sv]
package ffb_pkg;

  localparam int DEF_GRID_WIDTH  = 256;
  localparam int DEF_GRID_HEIGHT = 256;

  localparam int COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 24;

  // Source of the grid memory address.
  typedef enum logic [1:0] {
    ADDR_IN   = 2'd0,
    ADDR_ITEM = 2'd1,
    ADDR_NBR  = 2'd2,
    ADDR_CLR  = 2'd3
  } addr_sel_t;

  // Neighbour visited around the current frontier cell.
  typedef enum logic [1:0] {
    DIR_XP = 2'd0,
    DIR_XM = 2'd1,
    DIR_YP = 2'd2,
    DIR_YM = 2'd3
  } dir_t;

  typedef struct packed {
    logic      load_item;
    logic      load_was;
    logic      load_out;
    logic      grid_re;
    logic      grid_we;
    logic      grid_wdata;
    addr_sel_t addr_sel;
    logic      q_re;
    logic      q_we;
    logic      q_from_item;
    dir_t      dir;
    logic      clr_step;
  } ffb_cmd_t;

  typedef struct packed {
    logic item_in_grid;
    logic op_ignite;
    logic grid_bit;
    logic queue_empty;
    logic nb_valid;
    logic clr_last;
  } ffb_stat_t;

endpackage

[src/ffb_dpath.sv]
module ffb_dpath #(
  parameter int GRID_WIDTH  = ffb_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = ffb_pkg::DEF_GRID_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ffb_pkg::ffb_cmd_t         cmd,
  output ffb_pkg::ffb_stat_t        st,
  input  logic [ffb_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                      s_tuser,
  output logic [ffb_pkg::M_DATA_W-1:0] m_tdata
);
  import ffb_pkg::*;

  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int XW1   = XW + 1;
  localparam int YW1   = YW + 1;
  localparam int AW    = XW + YW;
  localparam int PTR_W = AW + 1;
  localparam int DEPTH = 2 ** AW;

  logic            grid_mem [DEPTH];
  logic [AW-1:0]   q_mem    [DEPTH];

  logic            grid_rdata;
  logic [AW-1:0]   q_rdata;
  logic [AW-1:0]   grid_addr;
  logic [AW-1:0]   clr_addr;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;

  logic [XW-1:0]   item_x;
  logic [YW-1:0]   item_y;
  logic            item_op;
  logic            item_in;
  logic            was;
  logic [COUNT_W-1:0] burned_out;
  logic            was_out;

  logic [XW-1:0]   cx;
  logic [YW-1:0]   cy;
  logic [AW-1:0]   nb_addr;
  logic            nb_valid;
  logic [AW-1:0]   q_wdata;
  logic [31:0]     tail32;
  logic            in_grid;

  assign cx = q_rdata[XW-1:0];
  assign cy = q_rdata[AW-1:XW];

  assign in_grid = (32'(s_tdata[7:0]) < 32'(GRID_WIDTH)) &&
                   (32'(s_tdata[15:8]) < 32'(GRID_HEIGHT));

  // Neighbour of the cell at the head of the frontier; only the ones
  // inside the grid are looked at.
  always_comb begin
    nb_addr  = q_rdata;
    nb_valid = 1'b0;
    unique case (cmd.dir)
      DIR_XP: begin
        nb_addr  = {cy, cx + XW'(1)};
        nb_valid = ({1'b0, cx} + XW1'(1)) < XW1'(GRID_WIDTH);
      end
      DIR_XM: begin
        nb_addr  = {cy, cx - XW'(1)};
        nb_valid = (cx != '0);
      end
      DIR_YP: begin
        nb_addr  = {cy + YW'(1), cx};
        nb_valid = ({1'b0, cy} + YW1'(1)) < YW1'(GRID_HEIGHT);
      end
      DIR_YM: begin
        nb_addr  = {cy - YW'(1), cx};
        nb_valid = (cy != '0);
      end
      default: begin
        nb_addr  = q_rdata;
        nb_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_IN:   grid_addr = {YW'(s_tdata[15:8]), XW'(s_tdata[7:0])};
      ADDR_ITEM: grid_addr = {item_y, item_x};
      ADDR_NBR:  grid_addr = nb_addr;
      ADDR_CLR:  grid_addr = clr_addr;
      default:   grid_addr = clr_addr;
    endcase
  end

  assign q_wdata = cmd.q_from_item ? {item_y, item_x} : nb_addr;

  always_ff @(posedge clk) begin
    if (cmd.grid_we) begin
      grid_mem[grid_addr] <= cmd.grid_wdata;
    end
    if (cmd.grid_re) begin
      grid_rdata <= grid_mem[grid_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_we) begin
      q_mem[tail[AW-1:0]] <= q_wdata;
    end
    if (cmd.q_re) begin
      q_rdata <= q_mem[head[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      head     <= '0;
      tail     <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.load_item) begin
        head <= '0;
        tail <= '0;
      end else begin
        if (cmd.q_re) begin
          head <= head + PTR_W'(1);
        end
        if (cmd.q_we) begin
          tail <= tail + PTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_x  <= XW'(s_tdata[7:0]);
      item_y  <= YW'(s_tdata[15:8]);
      item_op <= s_tuser;
      item_in <= in_grid;
    end
    if (cmd.load_was) begin
      was <= item_in & grid_rdata;
    end
  end

  // Every cell that entered the frontier has burned, so the tail is the count.
  assign tail32 = 32'(tail);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      burned_out <= (tail32 > 32'(COUNT_MAX)) ? COUNT_MAX : tail32[COUNT_W-1:0];
      was_out    <= was;
    end
  end

  assign m_tdata = {(M_DATA_W - COUNT_W - 1)'(0), was_out, burned_out};

  assign st.item_in_grid = item_in;
  assign st.op_ignite    = item_op;
  assign st.grid_bit     = grid_rdata;
  assign st.queue_empty  = (head == tail);
  assign st.nb_valid     = nb_valid;
  assign st.clr_last     = &clr_addr;

endmodule

[src/ffb_ctrl.sv]
module ffb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  ffb_pkg::ffb_stat_t st,
  output ffb_pkg::ffb_cmd_t  cmd
);
  import ffb_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_DEQ   = 7'b0001000,
    S_NRD   = 7'b0010000,
    S_NCHK  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  dir_t   dir;
  dir_t   dir_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.dir    = dir;
    state_next = state;
    dir_next   = dir;
    unique case (state)
      S_CLEAR: begin
        cmd.addr_sel   = ADDR_CLR;
        cmd.grid_we    = 1'b1;
        cmd.grid_wdata = 1'b0;
        cmd.clr_step   = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.addr_sel = ADDR_IN;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          cmd.grid_re   = 1'b1;
          state_next    = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.addr_sel = ADDR_ITEM;
        cmd.load_was = 1'b1;
        if (!st.item_in_grid) begin
          state_next = S_FIN;
        end else if (!st.op_ignite) begin
          cmd.grid_we    = 1'b1;
          cmd.grid_wdata = 1'b1;
          state_next     = S_FIN;
        end else if (st.grid_bit) begin
          // The starting tree burns at once and seeds the frontier.
          cmd.grid_we     = 1'b1;
          cmd.grid_wdata  = 1'b0;
          cmd.q_we        = 1'b1;
          cmd.q_from_item = 1'b1;
          state_next      = S_DEQ;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DEQ: begin
        if (st.queue_empty) begin
          state_next = S_FIN;
        end else begin
          cmd.q_re   = 1'b1;
          dir_next   = DIR_XP;
          state_next = S_NRD;
        end
      end
      S_NRD: begin
        cmd.addr_sel = ADDR_NBR;
        if (st.nb_valid) begin
          cmd.grid_re = 1'b1;
          state_next  = S_NCHK;
        end else if (dir == DIR_YM) begin
          state_next = S_DEQ;
        end else begin
          dir_next = dir_t'(dir + 2'd1);
        end
      end
      S_NCHK: begin
        cmd.addr_sel = ADDR_NBR;
        if (st.grid_bit) begin
          cmd.grid_we    = 1'b1;
          cmd.grid_wdata = 1'b0;
          cmd.q_we       = 1'b1;
        end
        if (dir == DIR_YM) begin
          state_next = S_DEQ;
        end else begin
          dir_next   = dir_t'(dir + 2'd1);
          state_next = S_NRD;
        end
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      dir      <= DIR_XP;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      dir   <= dir_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[src/forest_fire_flood_burn.sv]
// Channel  Direction  Signals                      Contents
// s_*      in         s_tvalid s_tready s_tdata    plant or ignite command, one cell
//                     s_tuser
// m_*      out        m_tvalid m_tready m_tdata    burned count and prior tree flag
//
// A plant, an ignite on an empty cell or an off-grid command goes from acceptance through
// S_LOOK to S_FIN, where its result is loaded into the output register. A burning ignite
// walks the frontier before S_FIN: per burned cell a queue read, then per neighbour a
// read state and, on the grid, a check state. After reset the grid is cleared one
// cell a cycle, 2**(clog2(width) + clog2(height)) cells (65536 by default), s_tready low.
// A new transaction is taken while a result waits on m_tready; it stalls at its end.
module forest_fire_flood_burn #(
  parameter int GRID_WIDTH  = ffb_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = ffb_pkg::DEF_GRID_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ffb_pkg::S_DATA_W-1:0] s_tdata,  // cell_x [7:0], cell_y [15:8]
  input  logic                         s_tuser,  // operation: 0 plant, 1 ignite
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ffb_pkg::M_DATA_W-1:0] m_tdata   // burned_count [16:0], was_tree [17]
);
  import ffb_pkg::*;

  ffb_cmd_t  cmd;
  ffb_stat_t st;

  ffb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ffb_dpath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .st      (st),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

endmodule
